>>> hw/rtl/jars_pkg.sv
// ============================================================================
// jars_pkg: shared types and constants of the JPEG AC run-length symbolizer
// Holds the command word passed from the classifier to the symbol emitter.
// ============================================================================
package jars_pkg;

  localparam int unsigned CoefWidth   = 12;
  localparam int unsigned RunWidth    = 6;
  localparam int unsigned SymbolWidth = 8;
  localparam int unsigned CatWidth    = 4;

  // Default depth of the command queue between front and back.
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [RunWidth-1:0]    RunMax     = 6'd63;
  localparam logic [SymbolWidth-1:0] ZrlSymbol  = 8'hF0;
  localparam logic [SymbolWidth-1:0] EobSymbol  = 8'h00;
  localparam logic [CoefWidth-1:0]   CoefMinNeg = 12'h800;
  localparam logic [CoefWidth-1:0]   CoefClamp  = 12'h801;

  // One command describes all words caused by one coefficient: a number of
  // ZRL words followed by one final word {run, cat}. EOB is run 0, cat 0.
  typedef struct packed {
    logic [1:0]                  zrl_cnt;
    logic [3:0]                  run;
    logic [CatWidth-1:0]         cat;
    logic signed [CoefWidth-1:0] amp;
  } jars_cmd_t;

endpackage

>>> hw/rtl/jars_front.sv
// ============================================================================
// jars_front: coefficient classifier
// Counts zero runs and turns each coefficient that causes output into one
// command for the queue.
// ============================================================================
module jars_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic signed [jars_pkg::CoefWidth-1:0] coef_i,
  input  logic                                  last_i,
  input  logic                                  fifo_full_i,
  output logic                                  in_ready_o,
  output logic                                  push_o,
  output jars_pkg::jars_cmd_t                   cmd_o
);

  logic [jars_pkg::RunWidth-1:0]  run_q, run_d;
  logic                           fire;
  logic                           is_zero;
  logic [jars_pkg::CoefWidth-1:0] raw;
  logic [jars_pkg::CoefWidth-1:0] neg;
  logic [10:0]                    mag;
  logic [jars_pkg::CatWidth-1:0]  cat;

  assign in_ready_o = !fifo_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_zero    = (coef_i == '0);
  assign push_o     = fire && (!is_zero || last_i);

  // The most negative code is clamped so its magnitude fits in 11 bits.
  assign raw = (coef_i == jars_pkg::CoefMinNeg) ? jars_pkg::CoefClamp : coef_i;
  assign neg = ~raw + 12'd1;
  assign mag = raw[11] ? neg[10:0] : raw[10:0];

  always_comb begin
    cat = '0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) begin
        cat = 4'(i + 1);
      end
    end
  end

  always_comb begin
    if (is_zero) begin
      cmd_o = '0;
    end else begin
      cmd_o.zrl_cnt = run_q[5:4];
      cmd_o.run     = run_q[3:0];
      cmd_o.cat     = cat;
      cmd_o.amp     = raw;
    end
  end

  always_comb begin
    run_d = run_q;
    if (fire) begin
      if (is_zero && !last_i) begin
        if (run_q != jars_pkg::RunMax) begin
          run_d = run_q + 6'd1;
        end
      end else begin
        run_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

>>> hw/rtl/jars_fifo.sv
// ============================================================================
// jars_fifo: command queue
// Small first-in first-out queue of commands between classifier and emitter.
// ============================================================================
module jars_fifo #(
  parameter int unsigned Depth = jars_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jars_pkg::jars_cmd_t wdata_i,
  input  logic                pop_i,
  output jars_pkg::jars_cmd_t rdata_o,
  output logic                full_o,
  output logic                valid_o
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  jars_pkg::jars_cmd_t     entry_q [Depth];
  logic [PtrWidth-1:0]     wptr_q, wptr_d;
  logic [PtrWidth-1:0]     rptr_q, rptr_d;
  logic [CntWidth-1:0]     count_q, count_d;
  logic                    do_push;
  logic                    do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/jars_back.sv
// ============================================================================
// jars_back: symbol emitter
// Expands each queued command into its ZRL words and final word, one word per
// cycle while the output is not stalled, into a registered output stage.
// ============================================================================
module jars_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  jars_pkg::jars_cmd_t                   cmd_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [jars_pkg::SymbolWidth-1:0]      symbol_o,
  output logic [jars_pkg::CatWidth-1:0]         cat_o,
  output logic signed [jars_pkg::CoefWidth-1:0] amp_o,
  output logic                                  last_o
);

  logic                                  valid_q, valid_d;
  logic [1:0]                            zrl_done_q, zrl_done_d;
  logic [jars_pkg::SymbolWidth-1:0]      symbol_q, symbol_d;
  logic [jars_pkg::CatWidth-1:0]         cat_q, cat_d;
  logic signed [jars_pkg::CoefWidth-1:0] amp_q, amp_d;
  logic                                  last_q, last_d;
  logic                                  load;
  logic                                  emit_zrl;

  assign load     = cmd_valid_i && (!valid_q || out_ready_i);
  assign emit_zrl = (zrl_done_q != cmd_i.zrl_cnt);
  assign pop_o    = load && !emit_zrl;

  always_comb begin
    valid_d    = valid_q && !out_ready_i;
    zrl_done_d = zrl_done_q;
    symbol_d   = symbol_q;
    cat_d      = cat_q;
    amp_d      = amp_q;
    last_d     = last_q;
    if (load) begin
      valid_d = 1'b1;
      if (emit_zrl) begin
        zrl_done_d = zrl_done_q + 2'd1;
        symbol_d   = jars_pkg::ZrlSymbol;
        cat_d      = '0;
        amp_d      = '0;
        last_d     = 1'b0;
      end else begin
        zrl_done_d = '0;
        symbol_d   = {cmd_i.run, cmd_i.cat};
        cat_d      = cmd_i.cat;
        amp_d      = cmd_i.amp;
        last_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      zrl_done_q <= '0;
    end else begin
      valid_q    <= valid_d;
      zrl_done_q <= zrl_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    symbol_q <= symbol_d;
    cat_q    <= cat_d;
    amp_q    <= amp_d;
    last_q   <= last_d;
  end

  assign out_valid_o = valid_q;
  assign symbol_o    = symbol_q;
  assign cat_o       = cat_q;
  assign amp_o       = amp_q;
  assign last_o      = last_q;

endmodule

>>> hw/rtl/jpeg_ac_run_length_symbolizer.sv
// ============================================================================
// jpeg_ac_run_length_symbolizer: JPEG baseline AC run-length symbolizer
// Turns zigzag-ordered AC coefficients into run/size symbols, ZRL and EOB.
// ============================================================================
// Usage: the slave stream takes one AC coefficient per word, with tlast set on
// the final coefficient of the block. The master stream returns one word per
// symbol: symbol, size category and amplitude, with tlast set on the final
// word caused by an input word. A zero coefficient that is not the last of
// the block produces nothing; a last zero produces EOB; a nonzero coefficient
// produces one ZRL per full 16 preceding zeros, then its run/size symbol.
// Throughput is one input word per cycle while the queue has room and one
// output word per cycle while the receiver is ready. The front classifier
// handles a word in the cycle it is accepted and writes at most one command
// to a queue; the emitter drains the queue one output word a cycle while the
// receiver is ready, so a coefficient with k ZRLs yields k + 1 output words.
// Each accepted command is written into the queue; the output register then
// loads it from the queue head. The queue absorbs ZRL bursts; when it fills
// (for example while the receiver stalls), tready drops on the slave side.
// Reset clears the zero-run counter, empties the queue and drops any pending
// output word. A stalled output word holds its value until it is taken.
// ============================================================================
module jpeg_ac_run_length_symbolizer #(
  parameter int unsigned FifoDepth = jars_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] coefficient, [15:12] zero
  input  logic        s_axis_tlast_i,   // last_coefficient
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] symbol, [11:8] size_category,
                                        // [23:12] amplitude_value
  output logic        m_axis_tlast_o    // last_of_run
);

  jars_pkg::jars_cmd_t                   push_cmd;
  jars_pkg::jars_cmd_t                   head_cmd;
  logic                                  push;
  logic                                  pop;
  logic                                  fifo_full;
  logic                                  fifo_valid;
  logic [jars_pkg::SymbolWidth-1:0]      symbol;
  logic [jars_pkg::CatWidth-1:0]         size_cat;
  logic signed [jars_pkg::CoefWidth-1:0] amplitude;

  // Classifier: keeps the zero-run count and forms one command per symbol group.
  jars_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .coef_i      (s_axis_tdata_i[11:0]),
    .last_i      (s_axis_tlast_i),
    .fifo_full_i (fifo_full),
    .in_ready_o  (s_axis_tready_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Command queue decoupling the classifier from the emitter.
  jars_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (fifo_full),
    .valid_o (fifo_valid)
  );

  // Emitter: expands each command into ZRL words and the final symbol word.
  jars_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .symbol_o    (symbol),
    .cat_o       (size_cat),
    .amp_o       (amplitude),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {amplitude, size_cat, symbol};

  // A ZRL word never closes the output of an input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (symbol == jars_pkg::ZrlSymbol) |-> !m_axis_tlast_o)
    else $error("ZRL word carries tlast");

  // Every word without tlast is a ZRL with zero size and amplitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      (symbol == jars_pkg::ZrlSymbol) && (size_cat == '0) && (amplitude == '0))
    else $error("non-final word is not a clean ZRL");

  // A final word with size zero must be a clean EOB.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && (size_cat == '0) |->
      (symbol == jars_pkg::EobSymbol) && (amplitude == '0))
    else $error("final word with size zero is not EOB");

  // The input side stalls only when the command queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> fifo_full)
    else $error("input stalled with room in the queue");

endmodule
